FILE: design/signed_int_seven_segment_lcd_writer_assert.svh
// assertion macros for the seven-segment lcd writer
`ifndef SIGNED_INT_SEVEN_SEGMENT_LCD_WRITER_ASSERT_SVH
`define SIGNED_INT_SEVEN_SEGMENT_LCD_WRITER_ASSERT_SVH

// same-cycle implication
`define LCDW_ASSERT_NOW(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define LCDW_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: design/lcdw_pkg.sv
// types, constants and segment table for the seven-segment lcd writer
`timescale 1ns / 1ps

package lcdw_pkg;

   localparam int NUM_POS     = 6;
   localparam int NUM_DIGITS  = 5;
   localparam int CODE_W      = 7;
   localparam int FLAG_W      = 3;
   localparam int ADDR_W      = 4;
   localparam int DATA_W      = 8;
   localparam int FRAME_W     = 17;
   localparam int MAG_W       = 15;
   localparam int QUOT_W      = 12;
   localparam int RSP_TDATA_W = 32;

   localparam logic [2:0]        FRAME_HEAD = 3'b101;
   localparam logic [CODE_W-1:0] CODE_BLANK = 7'h00;
   localparam logic [CODE_W-1:0] CODE_MINUS = 7'h02;
   localparam logic [ADDR_W-1:0] LAST_ADDR  = 4'd10;
   localparam logic [2:0]        LAST_IDX   = 3'd5;
   localparam logic [2:0]        LAST_STEP  = 3'd4;
   localparam logic [14:0]       MAG_MAX    = 15'h7FFF;
   // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for any 16-bit x
   localparam logic [15:0]       RECIP_10    = 16'hCCCD;
   localparam int                RECIP_SHIFT = 19;

   typedef enum logic {
      KIND_NUMBER = 1'b0,
      KIND_LEVEL  = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      FE_IDLE,
      FE_CONV,
      FE_PUSH
   } front_state_type;

   typedef struct packed {
      kind_type                        kind;
      logic [FLAG_W-1:0]               flags;
      logic [NUM_POS-1:0][CODE_W-1:0]  codes;
   } entry_type;

   function automatic logic [CODE_W-1:0] digit_code(input logic [3:0] digit);
      logic [CODE_W-1:0] code;
      unique case (digit)
         4'd0:    code = 7'h7D;
         4'd1:    code = 7'h60;
         4'd2:    code = 7'h3E;
         4'd3:    code = 7'h7A;
         4'd4:    code = 7'h63;
         4'd5:    code = 7'h5B;
         4'd6:    code = 7'h5F;
         4'd7:    code = 7'h70;
         4'd8:    code = 7'h7F;
         4'd9:    code = 7'h7B;
         default: code = CODE_BLANK;
      endcase
      return code;
   endfunction

endpackage

FILE: design/lcdw_front.sv
// front end: accepts requests, converts integers to segment codes, decodes battery level
`timescale 1ns / 1ps

module lcdw_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_func,
   input  logic [15:0]         req_value,
   output logic                push_valid,
   input  logic                push_ready,
   output lcdw_pkg::entry_type push_entry
);

   lcdw_pkg::front_state_type state_ff, state_in;

   lcdw_pkg::kind_type                kind_ff, kind_in;
   logic                              neg_ff, neg_in;
   logic [lcdw_pkg::MAG_W-1:0]        mag_ff, mag_in;
   logic [lcdw_pkg::FLAG_W-1:0]       flags_ff, flags_in;
   logic [4*lcdw_pkg::NUM_DIGITS-1:0] digits_ff, digits_in;
   logic [2:0]                        cnt_ff, cnt_in;

   logic                              req_fire;
   logic [15:0]                       abs_value;
   logic [lcdw_pkg::MAG_W-1:0]        mag_clamped;
   logic [lcdw_pkg::FLAG_W-1:0]       level_flags;
   logic [30:0]                       product;
   logic [lcdw_pkg::QUOT_W-1:0]       quot;
   logic [lcdw_pkg::MAG_W-1:0]        quot_x10;
   logic [lcdw_pkg::MAG_W-1:0]        rem_full;
   logic [2:0]                        num_digits;
   logic [2:0]                        pad_digits;
   logic [4*lcdw_pkg::NUM_DIGITS-1:0] aligned;
   logic [lcdw_pkg::NUM_POS-1:0][lcdw_pkg::CODE_W-1:0] slot_codes;
   logic [lcdw_pkg::NUM_POS-1:0][lcdw_pkg::CODE_W-1:0] codes;

   assign req_fire = req_tvalid && req_tready;

   // clamp the magnitude so the most negative value shows as -32767
   assign abs_value   = req_value[15] ? (~req_value + 16'd1) : req_value;
   assign mag_clamped = abs_value[15] ? lcdw_pkg::MAG_MAX : abs_value[14:0];

   always_comb begin
      case (req_value)
         16'd3:   level_flags = 3'b111;
         16'd2:   level_flags = 3'b110;
         16'd1:   level_flags = 3'b100;
         default: level_flags = 3'b000;
      endcase
   end

   // one decimal digit per cycle by reciprocal multiply
   assign product  = 31'(mag_ff) * 31'(lcdw_pkg::RECIP_10);
   assign quot     = product[lcdw_pkg::RECIP_SHIFT +: lcdw_pkg::QUOT_W];
   assign quot_x10 = lcdw_pkg::MAG_W'({quot, 3'b000}) + lcdw_pkg::MAG_W'({quot, 1'b0});
   assign rem_full = mag_ff - quot_x10;

   // digit count: highest nonzero digit, at least one
   always_comb begin
      if (digits_ff[19:16] != 4'd0) begin
         num_digits = 3'd5;
      end else if (digits_ff[15:12] != 4'd0) begin
         num_digits = 3'd4;
      end else if (digits_ff[11:8] != 4'd0) begin
         num_digits = 3'd3;
      end else if (digits_ff[7:4] != 4'd0) begin
         num_digits = 3'd2;
      end else begin
         num_digits = 3'd1;
      end
   end

   assign pad_digits = 3'd5 - num_digits;
   assign aligned    = digits_ff << {pad_digits, 2'b00};

   // left-aligned slots, most significant digit first, blanks after
   always_comb begin
      for (int i = 0; i < lcdw_pkg::NUM_DIGITS; i++) begin
         if (3'(i) < num_digits) begin
            slot_codes[i] = lcdw_pkg::digit_code(aligned[4*(lcdw_pkg::NUM_DIGITS-1-i) +: 4]);
         end else begin
            slot_codes[i] = lcdw_pkg::CODE_BLANK;
         end
      end
      slot_codes[lcdw_pkg::NUM_POS-1] = lcdw_pkg::CODE_BLANK;
   end

   always_comb begin
      if (neg_ff) begin
         codes[0] = lcdw_pkg::CODE_MINUS;
         for (int p = 1; p < lcdw_pkg::NUM_POS; p++) begin
            codes[p] = slot_codes[p-1];
         end
      end else begin
         codes = slot_codes;
      end
   end

   assign push_entry.kind  = kind_ff;
   assign push_entry.flags = flags_ff;
   assign push_entry.codes = codes;

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      neg_in     = neg_ff;
      mag_in     = mag_ff;
      flags_in   = flags_ff;
      digits_in  = digits_ff;
      cnt_in     = cnt_ff;
      push_valid = 1'b0;
      req_tready = 1'b0;
      unique case (state_ff)
         lcdw_pkg::FE_IDLE: begin
            req_tready = 1'b1;
         end
         lcdw_pkg::FE_CONV: begin
            mag_in    = lcdw_pkg::MAG_W'(quot);
            digits_in = {rem_full[3:0], digits_ff[19:4]};
            cnt_in    = cnt_ff + 3'd1;
            if (cnt_ff == lcdw_pkg::LAST_STEP) begin
               state_in = lcdw_pkg::FE_PUSH;
            end
         end
         lcdw_pkg::FE_PUSH: begin
            push_valid = 1'b1;
            req_tready = push_ready;
            if (push_ready) begin
               state_in = lcdw_pkg::FE_IDLE;
            end
         end
         default: begin
            state_in = lcdw_pkg::FE_IDLE;
         end
      endcase
      if (req_fire) begin
         kind_in  = req_func ? lcdw_pkg::KIND_LEVEL : lcdw_pkg::KIND_NUMBER;
         neg_in   = req_value[15];
         mag_in   = mag_clamped;
         flags_in = level_flags;
         cnt_in   = 3'd0;
         state_in = req_func ? lcdw_pkg::FE_PUSH : lcdw_pkg::FE_CONV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lcdw_pkg::FE_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      neg_ff    <= neg_in;
      mag_ff    <= mag_in;
      flags_ff  <= flags_in;
      digits_ff <= digits_in;
      cnt_ff    <= cnt_in;
   end

endmodule

FILE: design/lcdw_queue.sv
// two-entry queue between the front end and the frame writer
`timescale 1ns / 1ps

module lcdw_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  lcdw_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output lcdw_pkg::entry_type pop_entry
);

   lcdw_pkg::entry_type entries_ff [2];
   logic                wr_ptr_ff, wr_ptr_in;
   logic                rd_ptr_ff, rd_ptr_in;
   logic [1:0]          count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_entry  = entries_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: design/lcdw_back.sv
// back end: holds display state and sends six write frames per request
`timescale 1ns / 1ps

module lcdw_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  lcdw_pkg::entry_type             pop_entry,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [lcdw_pkg::ADDR_W-1:0]     rsp_write_address,
   output logic [lcdw_pkg::DATA_W-1:0]     rsp_write_data,
   output logic [lcdw_pkg::FRAME_W-1:0]    rsp_frame,
   output logic                            rsp_tlast
);

   logic [lcdw_pkg::NUM_POS-1:0][lcdw_pkg::CODE_W-1:0] codes_ff, codes_in;
   logic [lcdw_pkg::FLAG_W-1:0] flags_ff, flags_in;
   logic                        busy_ff, busy_in;
   logic [2:0]                  idx_ff, idx_in;

   logic                        rsp_fire;
   logic                        run_done;
   logic [2:0]                  pos;
   logic                        flag;

   assign rsp_fire  = rsp_tvalid && rsp_tready;
   assign run_done  = rsp_fire && (idx_ff == lcdw_pkg::LAST_IDX);
   // next entry is taken as the last frame of a run leaves
   assign pop_ready = !busy_ff || run_done;

   // frame k shows position 5-k at address 2k
   assign pos  = lcdw_pkg::LAST_IDX - idx_ff;
   assign flag = (pos < 3'd3) ? flags_ff[pos[1:0]] : 1'b0;

   assign rsp_tvalid        = busy_ff;
   assign rsp_tlast         = (idx_ff == lcdw_pkg::LAST_IDX);
   assign rsp_write_address = {idx_ff, 1'b0};
   assign rsp_write_data    = {flag, codes_ff[pos]};
   assign rsp_frame         = {lcdw_pkg::FRAME_HEAD, 2'b00, rsp_write_address, rsp_write_data};

   always_comb begin
      codes_in = codes_ff;
      flags_in = flags_ff;
      busy_in  = busy_ff;
      idx_in   = idx_ff;
      if (rsp_fire) begin
         idx_in = idx_ff + 3'd1;
      end
      if (run_done) begin
         busy_in = 1'b0;
      end
      if (pop_valid && pop_ready) begin
         busy_in = 1'b1;
         idx_in  = 3'd0;
         if (pop_entry.kind == lcdw_pkg::KIND_LEVEL) begin
            flags_in = pop_entry.flags;
         end else begin
            codes_in = pop_entry.codes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff <= '0;
         flags_ff <= '0;
         busy_ff  <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         codes_ff <= codes_in;
         flags_ff <= flags_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
      end
   end

endmodule

FILE: design/signed_int_seven_segment_lcd_writer.sv
// top level of the signed integer seven-segment lcd writer
//
//  channel | direction | tdata                                      | tuser | tlast
//  req     | in        | [15:0] value                               | func  | -
//  rsp     | out       | [3:0] address, [11:4] data, [28:12] frame  | -     | last
//
// every request gives six frames, one per cycle while rsp_tready is high
// a number takes the front end through accept, one reciprocal-multiplier step per digit
// and push, a level through accept and push; the push cycle also accepts the next request
// sustained rate is bounded by the six frames the writer sends per request
// synchronous reset clears control state, segment codes and battery flags
// a two-entry queue lets the front end keep accepting while rsp stalls, until the queue is full
`timescale 1ns / 1ps
`include "signed_int_seven_segment_lcd_writer_assert.svh"

module signed_int_seven_segment_lcd_writer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // [15:0] value
   input  logic                                req_tuser,   // [0] func
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [lcdw_pkg::RSP_TDATA_W-1:0]    rsp_tdata,   // [3:0] write_address, [11:4] write_data, [28:12] frame
   output logic                                rsp_tlast
);

   logic                            push_valid;
   logic                            push_ready;
   lcdw_pkg::entry_type             push_entry;
   logic                            pop_valid;
   logic                            pop_ready;
   lcdw_pkg::entry_type             pop_entry;
   logic [lcdw_pkg::ADDR_W-1:0]     write_address;
   logic [lcdw_pkg::DATA_W-1:0]     write_data;
   logic [lcdw_pkg::FRAME_W-1:0]    frame;

   lcdw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_func   (req_tuser),
      .req_value  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   lcdw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   lcdw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pop_valid         (pop_valid),
      .pop_ready         (pop_ready),
      .pop_entry         (pop_entry),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_write_address (write_address),
      .rsp_write_data    (write_data),
      .rsp_frame         (frame),
      .rsp_tlast         (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, frame, write_data, write_address};

   `LCDW_ASSERT_NOW(a_last_addr, clock, reset, rsp_tvalid && rsp_tlast, rsp_tdata[3:0] == lcdw_pkg::LAST_ADDR, "last frame not at address 10")
   `LCDW_ASSERT_NEXT(a_run_gapless, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid, "gap inside a frame run")
   `LCDW_ASSERT_NEXT(a_addr_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tdata[3:0] == $past(rsp_tdata[3:0]) + 4'd2, "address did not step by two")

endmodule

FILE: verif/signed_int_seven_segment_lcd_writer_test.sv
// self-checking testbench for the signed integer seven-segment lcd writer
`timescale 1ns / 1ps

module signed_int_seven_segment_lcd_writer_test;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 11;
   localparam int RANDOM_ITEMS  = 250;
   localparam int DRAIN_CYCLES  = 40;

   localparam logic [lcdw_pkg::CODE_W-1:0] SEGMENT_OF_DIGIT [10] = '{
      7'h7D, 7'h60, 7'h3E, 7'h7A, 7'h63, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
   };

   typedef struct {
      logic               hold;      // wait for every frame before going on
      lcdw_pkg::kind_type kind;
      logic [15:0]        value;
   } request_type;

   typedef struct packed {
      logic [lcdw_pkg::ADDR_W-1:0]  address;
      logic [lcdw_pkg::DATA_W-1:0]  data;
      logic [lcdw_pkg::FRAME_W-1:0] frame;
      logic                         last;
   } lcd_write_type;

   logic                             clock;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [15:0]                      req_tdata  = '0;
   logic                             req_tuser  = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [lcdw_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic                             rsp_tlast;

   request_type   request_queue[$];
   lcd_write_type write_queue[$];

   logic [lcdw_pkg::CODE_W-1:0] shown_codes [lcdw_pkg::NUM_POS];
   logic [lcdw_pkg::FLAG_W-1:0] level_flags;

   int error_count   = 0;
   int sent_count    = 0;
   int written_count = 0;
   int cycle_count   = 0;

   signed_int_seven_segment_lcd_writer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // update the display image and queue the six writes it produces
   task automatic predict_writes(input lcdw_pkg::kind_type kind, input logic [15:0] value);
      logic [16:0]                 magnitude;
      logic                        negative;
      logic [3:0]                  digits [lcdw_pkg::NUM_DIGITS];
      int                          num_digits;
      int                          pos;
      lcd_write_type               write;
      logic [lcdw_pkg::ADDR_W-1:0] address;
      logic                        flag;
      if (kind == lcdw_pkg::KIND_LEVEL) begin
         case (value)
            16'd3:   level_flags = 3'b111;
            16'd2:   level_flags = 3'b110;
            16'd1:   level_flags = 3'b100;
            default: level_flags = 3'b000;
         endcase
      end else begin
         negative  = value[15];
         magnitude = negative ? (17'h10000 - {1'b0, value}) : {1'b0, value};
         if (magnitude > 17'd32767)
            magnitude = 17'd32767;
         num_digits = 0;
         // least significant digit first
         do begin
            digits[num_digits] = 4'(magnitude % 10);
            num_digits++;
            magnitude = magnitude / 10;
         end while (magnitude != 0 && num_digits < lcdw_pkg::NUM_DIGITS);
         pos = 0;
         if (negative) begin
            shown_codes[pos] = lcdw_pkg::CODE_MINUS;
            pos++;
         end
         while (num_digits > 0) begin
            num_digits--;
            shown_codes[pos] = SEGMENT_OF_DIGIT[digits[num_digits]];
            pos++;
         end
         for (int i = pos; i < lcdw_pkg::NUM_POS; i++)
            shown_codes[i] = lcdw_pkg::CODE_BLANK;
      end
      for (int k = 0; k < lcdw_pkg::NUM_POS; k++) begin
         pos           = lcdw_pkg::NUM_POS - 1 - k;
         address       = lcdw_pkg::ADDR_W'(2 * k);
         flag          = (pos < lcdw_pkg::FLAG_W) ? level_flags[pos] : 1'b0;
         write.address = address;
         write.data    = {flag, shown_codes[pos]};
         write.frame   = {lcdw_pkg::FRAME_HEAD, 2'b00, address, flag, shown_codes[pos]};
         write.last    = (k == lcdw_pkg::NUM_POS - 1);
         write_queue.push_back(write);
      end
   endtask

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic logic [15:0] random_value(input lcdw_pkg::kind_type kind);
      int          pick;
      int          magnitude;
      logic [15:0] extremes [6];
      extremes = '{16'h7FFF, 16'h8001, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
      pick = $urandom_range(0, 9);
      if (kind == lcdw_pkg::KIND_LEVEL) begin
         if (pick < 6)
            return 16'($urandom_range(0, 3));
         else if (pick < 8)
            return 16'($urandom_range(0, 65535));
         else
            return extremes[$urandom_range(0, 5)];
      end
      if (pick < 3)
         return 16'($urandom_range(0, 65535));
      if (pick < 4)
         return extremes[$urandom_range(0, 5)];
      // spread over every digit count
      case ($urandom_range(0, 4))
         0:       magnitude = $urandom_range(0, 9);
         1:       magnitude = $urandom_range(10, 99);
         2:       magnitude = $urandom_range(100, 999);
         3:       magnitude = $urandom_range(1000, 9999);
         default: magnitude = $urandom_range(10000, 32767);
      endcase
      return $urandom_range(0, 1) ? 16'(-magnitude) : 16'(magnitude);
   endfunction

   task automatic add_request(input lcdw_pkg::kind_type kind, input logic [15:0] value);
      request_type item;
      item.hold  = 1'b0;
      item.kind  = kind;
      item.value = value;
      request_queue.push_back(item);
   endtask

   task automatic add_hold();
      request_type item;
      item.hold  = 1'b1;
      item.kind  = lcdw_pkg::KIND_NUMBER;
      item.value = '0;
      request_queue.push_back(item);
   endtask

   // request driver
   always @(posedge clock) begin
      request_type item;
      logic        idle;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_writes(lcdw_pkg::kind_type'(req_tuser), req_tdata);
            sent_count++;
         end
         if (!req_tvalid || req_tready) begin
            idle = (sent_count < 100 || sent_count >= 160)
                   && ($urandom_range(0, 99) < IDLE_PERCENT);
            if (request_queue.size() != 0 && request_queue[0].hold) begin
               if (write_queue.size() == 0)
                  void'(request_queue.pop_front());
               req_tvalid <= 1'b0;
            end else if (request_queue.size() != 0 && !idle) begin
               item = request_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= item.value;
               req_tuser  <= item.kind;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // write monitor
   always @(posedge clock) begin
      lcd_write_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            written_count++;
            if (write_queue.size() == 0) begin
               $display("%0t ns: unexpected write, expected none, actual 0x%0h", $time,
                        rsp_tdata);
               error_count++;
            end else begin
               want = write_queue.pop_front();
               check_field("write_address", 32'(want.address), 32'(rsp_tdata[3:0]));
               check_field("write_data", 32'(want.data), 32'(rsp_tdata[11:4]));
               check_field("frame", 32'(want.frame), 32'(rsp_tdata[28:12]));
               check_field("tdata padding", 32'd0, 32'(rsp_tdata[31:29]));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
         rsp_tready <= (written_count >= 300 && written_count < 700)
                       || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("signed_int_seven_segment_lcd_writer regression: fail");
         $finish;
      end
   end

   initial begin
      lcdw_pkg::kind_type kind;
      for (int i = 0; i < lcdw_pkg::NUM_POS; i++)
         shown_codes[i] = lcdw_pkg::CODE_BLANK;
      level_flags = '0;

      // level before any number: blank digits with flags
      add_request(lcdw_pkg::KIND_LEVEL, 16'd3);
      add_request(lcdw_pkg::KIND_NUMBER, 16'd0);
      add_request(lcdw_pkg::KIND_NUMBER, 16'd1);
      add_request(lcdw_pkg::KIND_NUMBER, 16'hFFFF);
      add_request(lcdw_pkg::KIND_NUMBER, 16'd9);
      add_request(lcdw_pkg::KIND_NUMBER, 16'd10);
      add_request(lcdw_pkg::KIND_NUMBER, 16'hFFF6);
      add_request(lcdw_pkg::KIND_NUMBER, 16'd12345);
      add_request(lcdw_pkg::KIND_NUMBER, 16'd2354);
      add_request(lcdw_pkg::KIND_NUMBER, 16'h7FFF);
      add_request(lcdw_pkg::KIND_NUMBER, 16'h8001);
      // most negative value is clamped
      add_request(lcdw_pkg::KIND_NUMBER, 16'h8000);
      add_request(lcdw_pkg::KIND_LEVEL, 16'd2);
      add_request(lcdw_pkg::KIND_LEVEL, 16'd1);
      add_request(lcdw_pkg::KIND_LEVEL, 16'd0);
      add_request(lcdw_pkg::KIND_LEVEL, 16'd3);
      // out of range levels clear the flags
      add_request(lcdw_pkg::KIND_LEVEL, 16'd4);
      add_request(lcdw_pkg::KIND_LEVEL, 16'd3);
      add_request(lcdw_pkg::KIND_LEVEL, 16'hFFFF);
      add_request(lcdw_pkg::KIND_LEVEL, 16'd2);
      add_request(lcdw_pkg::KIND_LEVEL, 16'h8003);
      add_request(lcdw_pkg::KIND_LEVEL, 16'd1);
      add_request(lcdw_pkg::KIND_NUMBER, 16'hD8F1);
      add_request(lcdw_pkg::KIND_LEVEL, 16'h7FFF);
      add_hold();

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         kind = $urandom_range(0, 2) == 0 ? lcdw_pkg::KIND_LEVEL : lcdw_pkg::KIND_NUMBER;
         add_request(kind, random_value(kind));
         if (n == RANDOM_ITEMS / 2)
            add_hold();
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_tvalid || write_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && write_queue.size() == 0) begin
         $display("signed_int_seven_segment_lcd_writer regression: pass");
      end else begin
         $display("signed_int_seven_segment_lcd_writer regression: fail");
      end
      $finish;
   end

endmodule
